@@ rtl/ctlp_pkg.sv @@
// ----------------------------------------------------------------------------
// Control packet parser package
// Types, state encodings and byte codes shared by the parser modules.
// ----------------------------------------------------------------------------
package ctlp_pkg;

  // Packet layout codes
  localparam logic [7:0] CTRL_START = 8'd2;
  localparam logic [7:0] CTRL_END   = 8'd3;
  localparam logic [7:0] TAG_SIZE   = 8'd0;
  localparam logic [7:0] TAG_NAME   = 8'd1;

  // Characters seen by the decimal size reader
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Only this many bytes of the size text are examined
  localparam logic [4:0] SIZE_TEXT_MAX = 5'd31;

  // Saturation bounds of the size magnitude, at the width of the product
  localparam int unsigned PROD_W = 52;
  localparam logic [PROD_W-1:0] MAG_POS = 52'h0_7FFF_FFFF_FFFF;
  localparam logic [PROD_W-1:0] MAG_NEG = 52'h0_8000_0000_0000;

  localparam logic [8:0] NAME_LIMIT_RST = 9'd256;
  localparam logic [7:0] NAME_MAX       = 8'd255;

  // Result item kinds and packet types
  localparam logic       KIND_NAME  = 1'b0;
  localparam logic       KIND_SUMM  = 1'b1;
  localparam logic [1:0] PT_ERROR   = 2'd0;

  // Output queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_CTRL = 3'd0,
    PH_TAG0 = 3'd1,
    PH_LEN0 = 3'd2,
    PH_SIZE = 3'd3,
    PH_TAG1 = 3'd4,
    PH_LEN1 = 3'd5,
    PH_NAME = 3'd6,
    PH_TAIL = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    NP_BLANK  = 2'd0,
    NP_DIGITS = 2'd1,
    NP_DONE   = 2'd2
  } num_phase_e;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         name_char;
    logic [1:0]         packet_type;
    logic signed [47:0] file_size;
    logic [7:0]         name_length;
    logic               last_result;
  } res_t;

  // Results raised by one accepted byte: a name byte, a summary, or both
  typedef struct packed {
    logic name_vld;
    logic summ_vld;
    res_t name_res;
    res_t summ_res;
  } push_t;

endpackage

@@ rtl/ctlp_if.sv @@
// ----------------------------------------------------------------------------
// Control packet parser channels
// Valid/ready channels for packet bytes in and result items out.
// ----------------------------------------------------------------------------
interface ctlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       is_last;

  modport source (output valid, output packet_byte, output is_last, input ready);
  modport sink   (input valid, input packet_byte, input is_last, output ready);
endinterface

interface ctlp_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [7:0]         name_char;
  logic [1:0]         packet_type;
  logic signed [47:0] file_size;
  logic [7:0]         name_length;
  logic               last_result;

  modport source (output valid, output result_kind, output name_char,
                  output packet_type, output file_size, output name_length,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input name_char,
                  input packet_type, input file_size, input name_length,
                  input last_result, output ready);
endinterface

@@ rtl/ctlp_parser.sv @@
// ----------------------------------------------------------------------------
// Control packet parser core
// Holds the per-packet parse state and turns each accepted byte into
// zero, one or two result items.
// ----------------------------------------------------------------------------
module ctlp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  logic [8:0]     name_limit_i,
  output ctlp_pkg::push_t push_o
);
  import ctlp_pkg::*;

  phase_e     phase_q, phase_d;
  num_phase_e nphase_q, nphase_d;
  logic [7:0]  left_q, left_d;
  logic [1:0]  kind_q, kind_d;
  logic [47:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [4:0]  taken_q, taken_d;
  logic [7:0]  emitted_q, emitted_d;
  logic        err_q, err_d;

  logic              is_blank, is_digit, is_sign;
  logic [PROD_W-1:0] prod, lim;
  logic              ok;
  logic [47:0]       mag;

  assign is_blank = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);

  // Ten times the magnitude plus the new digit, as two shifted adds.
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {48'd0, byte_i[3:0]};
  assign lim  = neg_q ? MAG_NEG : MAG_POS;

  always_comb begin
    phase_d   = phase_q;
    nphase_d  = nphase_q;
    left_d    = left_q;
    kind_d    = kind_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    taken_d   = taken_q;
    emitted_d = emitted_q;
    err_d     = err_q;
    push_o    = '0;
    ok        = 1'b0;
    mag       = '0;

    push_o.name_res.result_kind = KIND_NAME;
    push_o.name_res.name_char   = byte_i;

    if (!err_q) begin
      case (phase_q)
        PH_CTRL: begin
          if ((byte_i == CTRL_START) || (byte_i == CTRL_END)) begin
            kind_d  = byte_i[1:0] - 2'd1;
            phase_d = PH_TAG0;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_TAG0: begin
          if (byte_i == TAG_SIZE) phase_d = PH_LEN0;
          else err_d = 1'b1;
        end
        PH_LEN0: begin
          left_d  = byte_i;
          phase_d = (byte_i != 8'd0) ? PH_SIZE : PH_TAG1;
        end
        PH_SIZE: begin
          if (taken_q < SIZE_TEXT_MAX) begin
            taken_d = taken_q + 5'd1;
            case (nphase_q)
              NP_BLANK: begin
                if (is_blank) begin
                  nphase_d = NP_BLANK;
                end else if (is_sign) begin
                  neg_d    = (byte_i == CH_MINUS);
                  nphase_d = NP_DIGITS;
                end else if (is_digit) begin
                  nphase_d = NP_DIGITS;
                  acc_d    = (prod > lim) ? lim[47:0] : prod[47:0];
                end else begin
                  nphase_d = NP_DONE;
                end
              end
              NP_DIGITS: begin
                if (is_digit) acc_d = (prod > lim) ? lim[47:0] : prod[47:0];
                else nphase_d = NP_DONE;
              end
              default: begin
                nphase_d = nphase_q;
              end
            endcase
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PH_TAG1;
        end
        PH_TAG1: begin
          if (byte_i == TAG_NAME) phase_d = PH_LEN1;
          else err_d = 1'b1;
        end
        PH_LEN1: begin
          left_d  = byte_i;
          phase_d = (byte_i != 8'd0) ? PH_NAME : PH_TAIL;
        end
        PH_NAME: begin
          if ((({1'b0, emitted_q} + 9'd1) < name_limit_i) && (emitted_q != NAME_MAX)) begin
            push_o.name_vld = 1'b1;
            emitted_d       = emitted_q + 8'd1;
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PH_TAIL;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    if (last_i) begin
      ok  = !err_d && (phase_d == PH_TAIL);
      mag = neg_d ? (48'd0 - acc_d) : acc_d;
      push_o.summ_vld                 = 1'b1;
      push_o.summ_res.result_kind     = KIND_SUMM;
      push_o.summ_res.packet_type     = ok ? kind_d : PT_ERROR;
      push_o.summ_res.file_size       = ok ? signed'(mag) : 48'sd0;
      push_o.summ_res.name_length     = emitted_d;
      push_o.summ_res.last_result     = 1'b1;
      // The summary closes the packet: everything returns to its reset value.
      phase_d   = PH_CTRL;
      nphase_d  = NP_BLANK;
      left_d    = '0;
      kind_d    = '0;
      acc_d     = '0;
      neg_d     = 1'b0;
      taken_d   = '0;
      emitted_d = '0;
      err_d     = 1'b0;
    end

    if (!accept_i) begin
      push_o.name_vld = 1'b0;
      push_o.summ_vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CTRL;
      nphase_q  <= NP_BLANK;
      left_q    <= '0;
      kind_q    <= '0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      taken_q   <= '0;
      emitted_q <= '0;
      err_q     <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      nphase_q  <= nphase_d;
      left_q    <= left_d;
      kind_q    <= kind_d;
      acc_q     <= acc_d;
      neg_q     <= neg_d;
      taken_q   <= taken_d;
      emitted_q <= emitted_d;
      err_q     <= err_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> (phase_q == PH_CTRL) && !err_q && (emitted_q == 8'd0))
    else $error("parse state not cleared after the final byte of a packet");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'd0, acc_q} <= MAG_NEG)
    else $error("size magnitude beyond the saturation bound");

  a_name_only_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.name_vld |-> (phase_q == PH_NAME) && !err_q && (emitted_q != NAME_MAX))
    else $error("name byte item raised outside the name field");

endmodule

@@ rtl/ctlp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Control packet parser result queue
// Small register queue that takes up to two result items per cycle and
// presents one per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module ctlp_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctlp_pkg::push_t push_i,
  output logic            space_o,
  ctlp_out_if.source      res_o
);
  import ctlp_pkg::*;

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [1:0]       n_push;
  res_t             first_res;
  res_t             head;

  assign n_push    = {1'b0, push_i.name_vld} + {1'b0, push_i.summ_vld};
  assign first_res = push_i.name_vld ? push_i.name_res : push_i.summ_res;
  assign pop       = res_o.valid && res_o.ready;

  // Room for the worst case of one byte: a name item and a summary.
  assign space_o = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign cnt_d    = cnt_q + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_ptr_q] <= first_res;
    if (n_push == 2'd2) mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.summ_res;
  end

  assign head              = mem_q[rd_ptr_q];
  assign res_o.valid       = (cnt_q != '0);
  assign res_o.result_kind = head.result_kind;
  assign res_o.name_char   = head.name_char;
  assign res_o.packet_type = head.packet_type;
  assign res_o.file_size   = head.file_size;
  assign res_o.name_length = head.name_length;
  assign res_o.last_result = head.last_result;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push == 2'd0) && !pop |=> $stable(cnt_q))
    else $error("result queue count moved without a push or pop");

endmodule

@@ rtl/control_packet_tlv_parser_top.sv @@
// ----------------------------------------------------------------------------
// Control packet TLV parser
// Parses a control packet byte by byte, streams out the name bytes and
// gives a summary item with the packet type and decoded size.
// ----------------------------------------------------------------------------
// Usage: packet bytes enter on pkt_i, one byte per item, with is_last high
// on the final byte. Results leave on res_o: a name byte item while the name
// field passes (fewer of them than the name limit, and at most 255), and a
// summary item with last_result high for the final byte. cfg_we_i/cfg_wdata_i
// set the name limit (reset 256); the user must write them only while the
// block is idle, as the block itself does not enforce it. Each accepted byte
// is parsed in the cycle it is taken, and its result items wait in order in
// a four-entry result queue. One byte is accepted every cycle while the
// queue has room for two items; a byte that ends the name field and the
// packet at once raises two items, which leave the queue one at a time. A
// stalled receiver fills the queue and then pkt_i.ready falls, with no item
// lost. Reset clears parse state, empties the queue, restores the name limit.
// ----------------------------------------------------------------------------
module control_packet_tlv_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctlp_in_if.sink    pkt_i,
  ctlp_out_if.source res_o,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i
);
  import ctlp_pkg::*;

  logic       accept;
  logic       space;
  logic [8:0] name_limit_q;
  push_t      push;

  assign pkt_i.ready = space;
  assign accept      = pkt_i.valid && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q <= NAME_LIMIT_RST;
    end else if (cfg_we_i) begin
      name_limit_q <= cfg_wdata_i;
    end
  end

  ctlp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_i       (pkt_i.packet_byte),
    .last_i       (pkt_i.is_last),
    .name_limit_i (name_limit_q),
    .push_o       (push)
  );

  ctlp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule
